// File: src/fdce_pkg.sv
// Shared types, constants and helpers of the frame delta change encoder.
// No dependencies; every other file of the block but fdce_ram imports this package.
package fdce_pkg;

    // Default frame store address width (store depth is 2**PIXEL_BITS)
    localparam int PIXEL_BITS_DEF = 19;

    // Field widths
    localparam int INDEX_W  = 19;
    localparam int CHAN_W   = 8;
    localparam int BYTES_W  = 21;
    localparam int THR_W    = 8;
    localparam int DIVR_W   = 8;
    localparam int FPIX_W   = 20;
    localparam int SAD_W    = 10;
    localparam int PIXEL_W  = 3 * CHAN_W;

    // Stream payload widths, padded to whole bytes
    localparam int S_DATA_RAW = INDEX_W + 3 * CHAN_W;
    localparam int S_DATA_W   = ((S_DATA_RAW + 7) / 8) * 8;
    localparam int M_DATA_RAW = INDEX_W + 3 * CHAN_W + BYTES_W + 1;
    localparam int M_DATA_W   = ((M_DATA_RAW + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = FPIX_W;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIVIDER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIX = 2'd2;

    // Register reset values
    localparam logic [THR_W-1:0]   THRESHOLD_RST = 8'd3;
    localparam logic [DIVR_W-1:0]  DIVIDER_RST   = 8'd4;
    localparam logic [FPIX_W-1:0]  FRAME_PIX_RST = 20'd307200;
    localparam logic [BYTES_W-1:0] BUDGET_RST    = 21'd230400;

    // Byte accounting
    localparam logic [BYTES_W-1:0] HEADER_BYTES = 21'd12;
    localparam logic [BYTES_W-1:0] RECORD_BYTES = 21'd7;
    localparam logic [BYTES_W-1:0] COUNT_MAX    = 21'h1FFFFF;

    // Budget divider: dividend is 3 * frame_pixels
    localparam int DIVD_W    = FPIX_W + 2;
    localparam int DIV_STEPS = DIVD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Result kinds
    localparam logic KIND_RECORD  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [INDEX_W-1:0] index;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  red;
        logic [BYTES_W-1:0] bytes;
        logic               full;
        logic               last;
    } fdce_result_t;

    // Results handed together from the pixel stage to the output buffer
    typedef struct packed {
        logic         rec_valid;
        logic         sum_valid;
        fdce_result_t rec;
        fdce_result_t sum;
    } fdce_push_t;

    function automatic logic [CHAN_W-1:0] abs_diff8(input logic [CHAN_W-1:0] a,
                                                    input logic [CHAN_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// File: src/fdce_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module fdce_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read-first: a read at the write address returns the old word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/fdce_div.sv
// Byte budget unit: budget = 3 * frame_pixels / budget_divider, saturated.
// Restoring divider, one quotient bit per cycle. Depends on fdce_pkg.
module fdce_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [fdce_pkg::FPIX_W-1:0] frame_pixels,
    input  logic [fdce_pkg::DIVR_W-1:0] budget_divider,
    output logic                        busy,
    output logic [fdce_pkg::BYTES_W-1:0] budget
);
    import fdce_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIVR_W-1:0]    dvs_reg;
    logic [DIVR_W-1:0]    rem_reg;
    logic [DIVD_W-1:0]    quo_reg;
    logic [BYTES_W-1:0]   budget_reg;

    logic [DIVD_W-1:0]    dividend;
    logic [DIVR_W:0]      trial;
    logic                 ge;
    logic [DIVR_W:0]      diff;
    logic [DIVR_W-1:0]    rem_next;
    logic [DIVD_W-1:0]    quo_next;

    // 3 * frame_pixels as shift and add
    assign dividend = DIVD_W'(frame_pixels) + {1'b0, frame_pixels, 1'b0};

    // One restoring step
    always_comb begin
        trial    = {rem_reg, quo_reg[DIVD_W-1]};
        ge       = trial >= {1'b0, dvs_reg};
        diff     = trial - {1'b0, dvs_reg};
        rem_next = ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
        quo_next = {quo_reg[DIVD_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            budget_reg <= BUDGET_RST;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
            // a zero divider counts as one
            dvs_reg  <= (budget_divider == '0) ? DIVR_W'(1) : budget_divider;
            rem_reg  <= '0;
            quo_reg  <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_reg   <= 1'b0;
                budget_reg <= (quo_next > DIVD_W'(COUNT_MAX)) ? COUNT_MAX
                                                              : quo_next[BYTES_W-1:0];
            end
        end
    end

    assign busy   = busy_reg;
    assign budget = budget_reg;

endmodule

// File: src/fdce_out.sv
// Two-slot output buffer: holds a change record and a following summary.
// Depends on fdce_pkg.
module fdce_out (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fdce_pkg::fdce_push_t          push,
    output logic                          empty_next,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fdce_pkg::M_DATA_W-1:0] m_tdata,  // index, blue, green, red, bytes, full
    output logic                          m_tuser,  // kind
    output logic                          m_tlast
);
    import fdce_pkg::*;

    logic         out_valid_reg;
    fdce_result_t out_reg;
    logic         pend_valid_reg;
    fdce_result_t pend_reg;

    // Both slots are free after this edge
    assign empty_next = !pend_valid_reg && (!out_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (push.rec_valid || push.sum_valid) begin
            // Only pushed when empty_next holds
            out_valid_reg  <= 1'b1;
            out_reg        <= push.rec_valid ? push.rec : push.sum;
            pend_valid_reg <= push.rec_valid && push.sum_valid;
            pend_reg       <= push.sum;
        end else if (pend_valid_reg && (!out_valid_reg || m_tready)) begin
            out_valid_reg  <= 1'b1;
            out_reg        <= pend_reg;
            pend_valid_reg <= 1'b0;
        end else if (out_valid_reg && m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = M_DATA_W'({out_reg.full, out_reg.bytes, out_reg.red,
                                 out_reg.green, out_reg.blue, out_reg.index});

endmodule

// File: src/frame_delta_change_encoder.sv
// Frame delta change encoder, top level. Depends on fdce_pkg, fdce_ram, fdce_div, fdce_out.
// Holds the configuration registers, the frame store and the pixel compare stage.
//
// Takes one pixel per clock while no clearing pass or division runs and the output
// buffer has room. Each pixel reads the stored previous value at its index through the
// registered RAM read; the compare stage then compares and, on retiring, updates the
// byte count and writes the new value back; the write and the next read overlap, with a
// bypass for back-to-back pixels at the same index. A pixel giving both a change record
// and the end-of-frame summary fills both output slots, so when the next pixel also has
// a result of its own, input pauses there until both slots are free. After reset the
// frame store is cleared one entry per cycle, all 2**PIXEL_BITS entries (524288 at the
// default), before the first pixel is taken. Each known register write starts a bit-serial
// 22-bit budget division that holds off pixels. The configuration port is always ready.
module frame_delta_change_encoder #(
    parameter int PIXEL_BITS = fdce_pkg::PIXEL_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fdce_pkg::S_DATA_W-1:0]   s_tdata,   // pixel_index, blue, green, red
    input  logic                            s_tlast,   // frame_end
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fdce_pkg::M_DATA_W-1:0]   m_tdata,   // changed_index, out_blue,
                                                       // out_green, out_red,
                                                       // delta_bytes, full_frame
    output logic                            m_tuser,   // kind
    output logic                            m_tlast,   // last
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fdce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fdce_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fdce_pkg::*;

    localparam int DEPTH  = 1 << PIXEL_BITS;
    localparam int ADDR_W = PIXEL_BITS;

    // Configuration registers
    logic [THR_W-1:0]  thr_reg;
    logic [DIVR_W-1:0] divr_reg;
    logic [FPIX_W-1:0] fpix_reg;
    logic              div_start_reg;
    logic              cfg_accept;
    logic              cfg_known;

    // Store clearing pass
    logic              clr_active_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // Pixel stage
    logic               s1_valid_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic [INDEX_W-1:0] s1_index_reg;
    logic [CHAN_W-1:0]  s1_blue_reg;
    logic [CHAN_W-1:0]  s1_green_reg;
    logic [CHAN_W-1:0]  s1_red_reg;
    logic               s1_fend_reg;
    logic               byp_valid_reg;
    logic [PIXEL_W-1:0] byp_data_reg;

    // Frame byte accounting
    logic [BYTES_W-1:0] running_reg;
    logic               over_reg;

    // Input unpacking
    logic [INDEX_W-1:0] in_index;
    logic [CHAN_W-1:0]  in_blue;
    logic [CHAN_W-1:0]  in_green;
    logic [CHAN_W-1:0]  in_red;
    logic [ADDR_W-1:0]  in_addr;
    logic               accept;

    // Compare and update
    logic [PIXEL_W-1:0] ram_rdata;
    logic [PIXEL_W-1:0] prev;
    logic [PIXEL_W-1:0] s1_pixel;
    logic [SAD_W-1:0]   sad;
    logic [SAD_W-1:0]   thr3;
    logic               changed;
    logic [BYTES_W:0]   nb_sum;
    logic               nb_sat;
    logic [BYTES_W-1:0] rb_after;
    logic               over_after;
    logic               commit;
    logic               empty_next;
    fdce_push_t         push;

    // Store write port
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [PIXEL_W-1:0] ram_wdata;

    logic               div_busy;
    logic [BYTES_W-1:0] byte_budget;

    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_blue  = s_tdata[INDEX_W +: CHAN_W];
    assign in_green = s_tdata[INDEX_W + CHAN_W +: CHAN_W];
    assign in_red   = s_tdata[INDEX_W + 2 * CHAN_W +: CHAN_W];
    assign in_addr  = ADDR_W'(in_index);

    // Configuration writes; each known register restarts the budget division
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign cfg_known  = (cfg_index == REG_THRESHOLD) || (cfg_index == REG_DIVIDER) ||
                        (cfg_index == REG_FRAME_PIX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= THRESHOLD_RST;
            divr_reg      <= DIVIDER_RST;
            fpix_reg      <= FRAME_PIX_RST;
            div_start_reg <= 1'b0;
        end else begin
            div_start_reg <= cfg_accept && cfg_known;
            if (cfg_accept) begin
                unique case (cfg_index)
                    REG_THRESHOLD: thr_reg  <= cfg_data[THR_W-1:0];
                    REG_DIVIDER:   divr_reg <= cfg_data[DIVR_W-1:0];
                    REG_FRAME_PIX: fpix_reg <= cfg_data[FPIX_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    fdce_div u_div (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (div_start_reg),
        .frame_pixels   (fpix_reg),
        .budget_divider (divr_reg),
        .busy           (div_busy),
        .budget         (byte_budget)
    );

    // Clearing pass over the frame store after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == {ADDR_W{1'b1}}) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Frame store
    assign s1_pixel  = {s1_red_reg, s1_green_reg, s1_blue_reg};
    assign ram_we    = clr_active_reg || commit;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : s1_addr_reg;
    assign ram_wdata = clr_active_reg ? '0 : s1_pixel;

    fdce_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // Compare against the previous frame and update the byte count
    always_comb begin
        prev     = byp_valid_reg ? byp_data_reg : ram_rdata;
        sad      = SAD_W'(abs_diff8(s1_blue_reg,  prev[CHAN_W-1:0]))
                 + SAD_W'(abs_diff8(s1_green_reg, prev[CHAN_W +: CHAN_W]))
                 + SAD_W'(abs_diff8(s1_red_reg,   prev[2 * CHAN_W +: CHAN_W]));
        thr3     = {1'b0, thr_reg, 1'b0} + SAD_W'(thr_reg);
        changed  = !over_reg && (sad > thr3);
        nb_sum   = {1'b0, running_reg} + {1'b0, RECORD_BYTES};
        nb_sat   = nb_sum > {1'b0, COUNT_MAX};
        rb_after = !changed ? running_reg : (nb_sat ? COUNT_MAX : nb_sum[BYTES_W-1:0]);
        over_after = over_reg || (changed && nb_sat) || (rb_after > byte_budget);
    end

    // Results of the pixel in the compare stage
    always_comb begin
        push.rec_valid = s1_valid_reg && commit && changed;
        push.sum_valid = s1_valid_reg && commit && s1_fend_reg;
        push.rec.kind  = KIND_RECORD;
        push.rec.index = s1_index_reg;
        push.rec.blue  = s1_blue_reg;
        push.rec.green = s1_green_reg;
        push.rec.red   = s1_red_reg;
        push.rec.bytes = '0;
        push.rec.full  = 1'b0;
        push.rec.last  = !s1_fend_reg;
        push.sum.kind  = KIND_SUMMARY;
        push.sum.index = '0;
        push.sum.blue  = '0;
        push.sum.green = '0;
        push.sum.red   = '0;
        push.sum.bytes = rb_after;
        push.sum.full  = over_after;
        push.sum.last  = 1'b1;
    end

    // The compare stage retires when its results fit in the output buffer
    assign commit   = s1_valid_reg && ((!changed && !s1_fend_reg) || empty_next);
    assign s_tready = !clr_active_reg && !div_start_reg && !div_busy &&
                      (!s1_valid_reg || commit);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
            running_reg   <= HEADER_BYTES;
            over_reg      <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg  <= 1'b1;
                // same index written by the retiring pixel at this edge
                byp_valid_reg <= commit && (s1_addr_reg == in_addr);
            end else if (commit) begin
                s1_valid_reg <= 1'b0;
            end
            if (commit) begin
                if (s1_fend_reg) begin
                    running_reg <= HEADER_BYTES;
                    over_reg    <= 1'b0;
                end else begin
                    running_reg <= rb_after;
                    over_reg    <= over_after;
                end
            end
        end
    end

    // Pixel stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_addr_reg  <= in_addr;
            s1_index_reg <= in_index;
            s1_blue_reg  <= in_blue;
            s1_green_reg <= in_green;
            s1_red_reg   <= in_red;
            s1_fend_reg  <= s_tlast;
            byp_data_reg <= s1_pixel;
        end
    end

    fdce_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .empty_next (empty_next),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
